@@ rtl/core/clnw_pkg.sv @@
package clnw_pkg;

    // Request codes
    localparam logic [2:0] CMD_INIT  = 3'd0;
    localparam logic [2:0] CMD_CLEAR = 3'd1;
    localparam logic [2:0] CMD_GOTO  = 3'd2;
    localparam logic [2:0] CMD_CHAR  = 3'd3;
    localparam logic [2:0] CMD_DEC   = 3'd4;

    localparam int unsigned LINE_TWO_BASE_DEFAULT = 64;

    // Panel timing in microseconds
    localparam logic [12:0] NIB_WAIT   = 13'd100;
    localparam logic [12:0] BYTE_WAIT  = 13'd50;
    localparam logic [12:0] CLEAR_WAIT = 13'd2000;
    localparam logic [12:0] WAKE0_WAIT = 13'd5000;
    localparam logic [12:0] WAKE1_WAIT = 13'd150;
    localparam logic [15:0] POWER_WAIT = 16'd40000;

    // Full init run: wake nibbles 3,3,3,2 then 0x28, 0x0C, 0x06, 0x01
    localparam logic [47:0] INIT_SEQ   = 48'h3332_280C_0601;
    localparam logic [7:0]  CLEAR_BYTE = 8'h01;
    localparam logic [7:0]  GOTO_BYTE  = 8'h80;
    localparam logic [3:0]  ASCII_HI   = 4'h3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } clnw_state_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] value;
        logic       line;
        logic [5:0] pos;
    } clnw_req_t;

    typedef struct packed {
        logic        rs;
        logic [3:0]  nibble;
        logic [15:0] wait_before_us;
        logic [12:0] wait_after_us;
        logic        last;
    } clnw_xfer_t;

endpackage

@@ rtl/core/char_lcd_nibble_writer_unit.sv @@
// Channel   Direction  Signals                          Payload
// -------   ---------  -------------------------------  ------------------------------
// request   in         req_valid / req_ready / req      cmd, value, line, pos
// transfer  out        xfer_valid / xfer_ready / xfer   rs, nibble, waits, last
//
// One request at a time. The accept cycle loads a 48-bit nibble shift register;
// then one nibble leaves per cycle while the output is not stalled: 2 nibbles for
// clear, goto and character, 12 for init. A decimal request first runs a bit-serial
// binary to BCD conversion of its 8-bit value, then emits 2, 4 or 6 nibbles. The
// output register lets the next request be taken while the final transfer still
// waits. Reset clears control state only; a stall on xfer_ready holds emission in place.
module char_lcd_nibble_writer_unit
    import clnw_pkg::*;
#(
    parameter int unsigned LINE_TWO_BASE = LINE_TWO_BASE_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  clnw_req_t  req,
    output logic       xfer_valid,
    input  logic       xfer_ready,
    output clnw_xfer_t xfer
);

    clnw_state_t state_reg, state_next;

    // Sequencer datapath
    logic [47:0] shift_reg, shift_next;
    logic [3:0]  idx_reg, idx_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic        rs_reg, rs_next;

    // Binary to BCD, one input bit per cycle
    logic [7:0]  bin_reg, bin_next;
    logic [11:0] bcd_reg, bcd_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    clnw_xfer_t  out_reg, out_next;

    // FSM controls
    logic accept;
    logic slot_free;
    logic conv_step;
    logic emit_go;
    logic last_nib;
    logic cmd_known;

    // Helpers
    logic [7:0]  goto_addr;
    logic [11:0] bcd_adj;
    logic [11:0] bcd_step;
    logic        low_nib;
    logic [12:0] wait_after;

    assign slot_free = !out_valid_reg || xfer_ready;
    assign accept    = req_valid && req_ready;
    assign last_nib  = (idx_reg == (cnt_reg - 4'd1));
    assign cmd_known = req.cmd inside {CMD_INIT, CMD_CLEAR, CMD_GOTO, CMD_CHAR, CMD_DEC};

    assign goto_addr = {2'b00, req.pos} + (req.line ? 8'(LINE_TWO_BASE) : 8'd0);

    // Add 3 to each BCD digit of 5 or more, then shift in the next binary bit
    always_comb
    begin
        for (int d = 0; d < 3; d++)
        begin
            bcd_adj[d*4 +: 4] = (bcd_reg[d*4 +: 4] >= 4'd5) ?
                                bcd_reg[d*4 +: 4] + 4'd3 : bcd_reg[d*4 +: 4];
        end
        bcd_step = {bcd_adj[10:0], bin_reg[7]};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd_known)
                begin
                    state_next = (req.cmd == CMD_DEC) ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV:
            begin
                if (bit_cnt_reg == 3'd7)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go && last_nib)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        req_ready = 1'b0;
        conv_step = 1'b0;
        emit_go   = 1'b0;
        case (state_reg)
            ST_IDLE: req_ready = 1'b1;
            ST_CONV: conv_step = 1'b1;
            ST_EMIT: emit_go   = slot_free;
            default: req_ready = 1'b0;
        endcase
    end

    // Per-nibble timing
    always_comb
    begin
        // init: wake nibbles are single transfers, bytes start at index 4
        if (cmd_reg == CMD_INIT)
        begin
            low_nib = idx_reg[0] && (idx_reg >= 4'd4);
        end
        else
        begin
            low_nib = idx_reg[0];
        end
        wait_after = NIB_WAIT;
        if (low_nib)
        begin
            wait_after = wait_after + BYTE_WAIT;
        end
        if (cmd_reg == CMD_INIT && idx_reg == 4'd0)
        begin
            wait_after = wait_after + WAKE0_WAIT;
        end
        if (cmd_reg == CMD_INIT && idx_reg == 4'd1)
        begin
            wait_after = wait_after + WAKE1_WAIT;
        end
        if (last_nib && (cmd_reg == CMD_INIT || cmd_reg == CMD_CLEAR))
        begin
            wait_after = wait_after + CLEAR_WAIT;
        end
    end

    // Datapath next values
    always_comb
    begin
        shift_next     = shift_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        cmd_next       = cmd_reg;
        rs_next        = rs_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (xfer_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            cmd_next     = req.cmd;
            idx_next     = 4'd0;
            cnt_next     = 4'd2;
            rs_next      = 1'b0;
            bin_next     = req.value;
            bcd_next     = '0;
            bit_cnt_next = 3'd0;
            case (req.cmd)
                CMD_INIT:
                begin
                    shift_next = INIT_SEQ;
                    cnt_next   = 4'd12;
                end
                CMD_CLEAR: shift_next = {CLEAR_BYTE, 40'd0};
                CMD_GOTO:  shift_next = {GOTO_BYTE | goto_addr, 40'd0};
                CMD_CHAR:
                begin
                    shift_next = {req.value, 40'd0};
                    rs_next    = 1'b1;
                end
                CMD_DEC:   rs_next = 1'b1;
                default:   shift_next = shift_reg;
            endcase
        end

        if (conv_step)
        begin
            bcd_next     = bcd_step;
            bin_next     = {bin_reg[6:0], 1'b0};
            bit_cnt_next = bit_cnt_reg + 3'd1;
            if (bit_cnt_reg == 3'd7)
            begin
                // Left-align the digits, dropping leading zeros
                if (bcd_step[11:8] != 4'd0)
                begin
                    shift_next = {ASCII_HI, bcd_step[11:8], ASCII_HI, bcd_step[7:4],
                                  ASCII_HI, bcd_step[3:0], 24'd0};
                    cnt_next   = 4'd6;
                end
                else if (bcd_step[7:4] != 4'd0)
                begin
                    shift_next = {ASCII_HI, bcd_step[7:4], ASCII_HI, bcd_step[3:0],
                                  32'd0};
                    cnt_next   = 4'd4;
                end
                else
                begin
                    shift_next = {ASCII_HI, bcd_step[3:0], 40'd0};
                    cnt_next   = 4'd2;
                end
            end
        end

        if (emit_go)
        begin
            out_next.rs             = rs_reg;
            out_next.nibble         = shift_reg[47:44];
            out_next.wait_before_us = (cmd_reg == CMD_INIT && idx_reg == 4'd0) ?
                                      POWER_WAIT : 16'd0;
            out_next.wait_after_us  = wait_after;
            out_next.last           = last_nib;
            out_valid_next          = 1'b1;
            shift_next              = {shift_reg[43:0], 4'd0};
            idx_next                = idx_reg + 4'd1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        shift_reg   <= shift_next;
        idx_reg     <= idx_next;
        cnt_reg     <= cnt_next;
        cmd_reg     <= cmd_next;
        rs_reg      <= rs_next;
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        bit_cnt_reg <= bit_cnt_next;
        out_reg     <= out_next;
    end

    assign xfer_valid = out_valid_reg;
    assign xfer       = out_reg;

endmodule
